@@ design/frot_pkg.sv @@
// Shared constants and helpers for the NV12 frame rotator.
// No dependencies; used by every module of the block.
package frot_pkg;

	// Default frame limits in pixels
	localparam int unsigned MAX_WIDTH_DEF  = 256;
	localparam int unsigned MAX_HEIGHT_DEF = 256;

	// Field and derived widths
	localparam int unsigned DIM_W      = 9;
	localparam int unsigned WH_W       = 2 * DIM_W;
	localparam int unsigned SIZE_W     = WH_W + 1;
	localparam int unsigned BYTE_W     = 8;
	localparam int unsigned MODE_W     = 2;
	localparam int unsigned CFG_IDX_W  = 2;
	localparam int unsigned CFG_DATA_W = 9;

	// Configuration register indexes
	localparam logic [CFG_IDX_W-1:0] REG_FRAME_WIDTH  = 2'd0;
	localparam logic [CFG_IDX_W-1:0] REG_FRAME_HEIGHT = 2'd1;
	localparam logic [CFG_IDX_W-1:0] REG_ROTATE_MODE  = 2'd2;

	// Rotation modes
	localparam logic [MODE_W-1:0] MODE_TRANSPOSE = 2'd0;
	localparam logic [MODE_W-1:0] MODE_ROT90     = 2'd1;
	localparam logic [MODE_W-1:0] MODE_ROT270    = 2'd2;

	// Input item kinds
	localparam logic KIND_LOAD    = 1'b0;
	localparam logic KIND_REQUEST = 1'b1;

	// Effective dimension: even, at least 2, at most the largest even value
	// not above the limit
	function automatic logic [DIM_W-1:0] eff_dim(input logic [DIM_W-1:0] v,
			input int unsigned maxv);
		logic [DIM_W-1:0] e;
		int unsigned      m;
		m = maxv & ~32'd1;
		e = {v[DIM_W-1:1], 1'b0};
		if (e < DIM_W'(2))
			e = DIM_W'(2);
		if (32'(e) > m)
			e = DIM_W'(m);
		return e;
	endfunction

endpackage

@@ design/frot_store.sv @@
// Frame store: single write port, single read port, registered read data.
// Depends on frot_pkg for the byte width.
module frot_store #(
	parameter int unsigned DEPTH = 98304,
	parameter int unsigned AW    = 17
) (
	input  logic                         clk,
	input  logic                         we,
	input  logic [AW-1:0]                waddr,
	input  logic [frot_pkg::BYTE_W-1:0]  wdata,
	input  logic                         re,
	input  logic [AW-1:0]                raddr,
	output logic [frot_pkg::BYTE_W-1:0]  rdata
);

	logic [frot_pkg::BYTE_W-1:0] mem [DEPTH];
	logic [frot_pkg::BYTE_W-1:0] rdata_q;

	always_ff @(posedge clk) begin
		if (we)
			mem[waddr] <= wdata;
	end

	always_ff @(posedge clk) begin
		if (re)
			rdata_q <= mem[raddr];
	end

	assign rdata = rdata_q;

endmodule

@@ design/frot_ctrl.sv @@
// Load counter, output scan position and store address generation.
// Depends on frot_pkg; drives the ports of frot_store.
module frot_ctrl #(
	parameter int unsigned AW = 17
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          restart,
	input  logic                          load_fire,
	input  logic                          req_fire,
	input  logic [frot_pkg::BYTE_W-1:0]   pixel_byte,
	input  logic [frot_pkg::DIM_W-1:0]    eff_w,
	input  logic [frot_pkg::DIM_W-1:0]    eff_h,
	input  logic [frot_pkg::WH_W-1:0]     wh,
	input  logic [frot_pkg::SIZE_W-1:0]   size,
	input  logic [frot_pkg::MODE_W-1:0]   mode,
	output logic                          we,
	output logic [AW-1:0]                 waddr,
	output logic [frot_pkg::BYTE_W-1:0]   wdata,
	output logic                          re,
	output logic [AW-1:0]                 raddr,
	output logic                          last
);

	localparam int unsigned DW = frot_pkg::DIM_W;

	logic [frot_pkg::SIZE_W-1:0] load_count_q;
	logic [frot_pkg::SIZE_W-1:0] load_count_nxt;
	logic                        frame_ready_q;
	logic [DW-1:0]               out_row_q;
	logic [DW-1:0]               out_col_q;
	logic                        out_plane_q;

	logic [DW-1:0]               ysel;
	logic [DW-1:0]               xsel;
	logic [DW-2:0]               pair_col;
	logic [DW-1:0]               rows;
	logic [frot_pkg::WH_W-1:0]   prod;
	logic [frot_pkg::SIZE_W-1:0] idx;
	logic                        col_wrap;
	logic                        row_wrap;

	assign load_count_nxt = load_count_q + 1'b1;
	assign pair_col       = out_col_q[DW-1:1];
	assign rows           = out_plane_q ? (eff_w >> 1) : eff_w;
	assign col_wrap       = (out_col_q == eff_h - 1'b1);
	assign row_wrap       = (out_row_q == rows - 1'b1);

	// Source row and column for the current output position
	always_comb begin
		case (mode)
			frot_pkg::MODE_TRANSPOSE: begin
				ysel = out_plane_q ? {1'b0, pair_col} : out_col_q;
				xsel = out_row_q;
			end
			frot_pkg::MODE_ROT270: begin
				ysel = out_plane_q ? {1'b0, pair_col} : out_col_q;
				xsel = out_plane_q ? (eff_w >> 1) - 1'b1 - out_row_q
				                   : eff_w - 1'b1 - out_row_q;
			end
			default: begin
				ysel = out_plane_q ? (eff_h >> 1) - 1'b1 - {1'b0, pair_col}
				                   : eff_h - 1'b1 - out_col_q;
				xsel = out_row_q;
			end
		endcase
	end

	assign prod = frot_pkg::WH_W'(eff_w) * frot_pkg::WH_W'(ysel);

	always_comb begin
		if (out_plane_q)
			idx = frot_pkg::SIZE_W'(wh) + frot_pkg::SIZE_W'(prod)
			    + frot_pkg::SIZE_W'({xsel, 1'b0}) + frot_pkg::SIZE_W'(out_col_q[0]);
		else
			idx = frot_pkg::SIZE_W'(prod) + frot_pkg::SIZE_W'(xsel);
	end

	assign we    = load_fire && !frame_ready_q;
	assign waddr = AW'(load_count_q);
	assign wdata = pixel_byte;
	assign re    = req_fire && frame_ready_q;
	assign raddr = AW'(idx);
	assign last  = re && col_wrap && row_wrap && out_plane_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			load_count_q  <= '0;
			frame_ready_q <= 1'b0;
			out_row_q     <= '0;
			out_col_q     <= '0;
			out_plane_q   <= 1'b0;
		end else if (restart || last) begin
			load_count_q  <= '0;
			frame_ready_q <= 1'b0;
			out_row_q     <= '0;
			out_col_q     <= '0;
			out_plane_q   <= 1'b0;
		end else begin
			if (we) begin
				load_count_q <= load_count_nxt;
				if (load_count_nxt >= size)
					frame_ready_q <= 1'b1;
			end
			if (re) begin
				if (col_wrap) begin
					out_col_q <= '0;
					if (row_wrap) begin
						out_row_q   <= '0;
						out_plane_q <= 1'b1;
					end else begin
						out_row_q <= out_row_q + 1'b1;
					end
				end else begin
					out_col_q <= out_col_q + 1'b1;
				end
			end
		end
	end

endmodule

@@ design/nv12_frame_rotator_core.sv @@
// NV12 frame rotator: top level with configuration, handshakes and output register.
// Depends on frot_pkg, frot_ctrl and frot_store.
//
// The block takes one NV12 frame as a stream of byte requests (kind 0): the
// width x height luma plane in raster order, then the interleaved chroma plane.
// Once the frame is complete, each request of kind 1 returns the next byte of
// the frame transposed, rotated 90 or rotated 270 degrees clockwise; the output
// is height wide and width tall, chroma U,V pairs stay together, and out_last
// marks the final byte, after which the next frame may be loaded. Requests
// before the frame is complete and loads during emission give no result. A
// load request is one store write. An emit request goes through the store
// read, whose data is registered, then the output register; the next request
// is taken once that read has landed and the output register is free or being
// drained. A configuration write to a listed register restarts the block (the
// store keeps its contents); any configuration write holds in_ready low while
// the frame area product is registered. The store is not cleared after reset:
// a frame is only emitted after every byte of it has been loaded.
module nv12_frame_rotator_core #(
	parameter int unsigned MAX_WIDTH  = frot_pkg::MAX_WIDTH_DEF,
	parameter int unsigned MAX_HEIGHT = frot_pkg::MAX_HEIGHT_DEF
) (
	input  logic                             clk,
	input  logic                             arst_n,
	// source byte / emit request channel
	input  logic                             in_valid,
	output logic                             in_ready,
	input  logic                             kind,
	input  logic [frot_pkg::BYTE_W-1:0]      pixel_byte,
	// rotated byte channel
	output logic                             out_valid,
	input  logic                             out_ready,
	output logic [frot_pkg::BYTE_W-1:0]      out_byte,
	output logic                             out_last,
	// configuration write channel
	input  logic                             cfg_valid,
	output logic                             cfg_ready,
	input  logic [frot_pkg::CFG_IDX_W-1:0]   cfg_index,
	input  logic [frot_pkg::CFG_DATA_W-1:0]  cfg_data
);

	localparam int unsigned DEPTH = MAX_WIDTH * MAX_HEIGHT * 3 / 2;
	localparam int unsigned AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1;

	// Configuration registers
	logic [frot_pkg::DIM_W-1:0]  frame_width_q;
	logic [frot_pkg::DIM_W-1:0]  frame_height_q;
	logic [frot_pkg::MODE_W-1:0] rotate_mode_q;
	logic                        settle_q;
	logic [frot_pkg::WH_W-1:0]   wh_q;

	logic [frot_pkg::DIM_W-1:0]  eff_w;
	logic [frot_pkg::DIM_W-1:0]  eff_h;
	logic [frot_pkg::SIZE_W-1:0] size;
	logic                        cfg_fire;
	logic                        restart;

	// Request path
	logic                        in_fire;
	logic                        load_fire;
	logic                        req_fire;
	logic                        mem_we;
	logic [AW-1:0]               mem_waddr;
	logic [frot_pkg::BYTE_W-1:0] mem_wdata;
	logic                        mem_re;
	logic [AW-1:0]               mem_raddr;
	logic [frot_pkg::BYTE_W-1:0] mem_rdata;
	logic                        last;

	// Read in flight and output register
	logic                        rd_s1;
	logic                        last_s1;
	logic                        out_valid_q;
	logic [frot_pkg::BYTE_W-1:0] out_byte_q;
	logic                        out_last_q;

	assign cfg_ready = 1'b1;
	assign cfg_fire  = cfg_valid && cfg_ready;
	// writes beyond the register list change nothing and do not restart
	assign restart   = cfg_fire && (cfg_index == frot_pkg::REG_FRAME_WIDTH
	                             || cfg_index == frot_pkg::REG_FRAME_HEIGHT
	                             || cfg_index == frot_pkg::REG_ROTATE_MODE);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			frame_width_q  <= frot_pkg::DIM_W'(256);
			frame_height_q <= frot_pkg::DIM_W'(256);
			rotate_mode_q  <= frot_pkg::MODE_ROT90;
			settle_q       <= 1'b1;
		end else begin
			settle_q <= cfg_fire;
			if (cfg_fire) begin
				unique case (cfg_index)
					frot_pkg::REG_FRAME_WIDTH:  frame_width_q  <= cfg_data;
					frot_pkg::REG_FRAME_HEIGHT: frame_height_q <= cfg_data;
					frot_pkg::REG_ROTATE_MODE:
						rotate_mode_q <= cfg_data[frot_pkg::MODE_W-1:0];
					default: ;
				endcase
			end
		end
	end

	assign eff_w = frot_pkg::eff_dim(frame_width_q, MAX_WIDTH);
	assign eff_h = frot_pkg::eff_dim(frame_height_q, MAX_HEIGHT);

	// Luma plane area, registered straight after the multiply
	always_ff @(posedge clk) begin
		wh_q <= frot_pkg::WH_W'(eff_w) * frot_pkg::WH_W'(eff_h);
	end

	// Whole frame: luma plus half as much chroma
	assign size = frot_pkg::SIZE_W'(wh_q) + frot_pkg::SIZE_W'(wh_q >> 1);

	// One request at a time through the store read; the output register must
	// be free by the time the read data lands
	assign in_ready  = !settle_q && !rd_s1 && (!out_valid_q || out_ready);
	assign in_fire   = in_valid && in_ready;
	assign load_fire = in_fire && (kind == frot_pkg::KIND_LOAD);
	assign req_fire  = in_fire && (kind == frot_pkg::KIND_REQUEST);

	frot_ctrl #(
		.AW(AW)
	) u_ctrl (
		.clk        (clk),
		.arst_n     (arst_n),
		.restart    (restart),
		.load_fire  (load_fire),
		.req_fire   (req_fire),
		.pixel_byte (pixel_byte),
		.eff_w      (eff_w),
		.eff_h      (eff_h),
		.wh         (wh_q),
		.size       (size),
		.mode       (rotate_mode_q),
		.we         (mem_we),
		.waddr      (mem_waddr),
		.wdata      (mem_wdata),
		.re         (mem_re),
		.raddr      (mem_raddr),
		.last       (last)
	);

	frot_store #(
		.DEPTH(DEPTH),
		.AW   (AW)
	) u_store (
		.clk   (clk),
		.we    (mem_we),
		.waddr (mem_waddr),
		.wdata (mem_wdata),
		.re    (mem_re),
		.raddr (mem_raddr),
		.rdata (mem_rdata)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rd_s1       <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			rd_s1 <= mem_re;
			if (rd_s1)
				out_valid_q <= 1'b1;
			else if (out_ready)
				out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (mem_re)
			last_s1 <= last;
		if (rd_s1) begin
			out_byte_q <= mem_rdata;
			out_last_q <= last_s1;
		end
	end

	assign out_valid = out_valid_q;
	assign out_byte  = out_byte_q;
	assign out_last  = out_last_q;

endmodule
